// ===== hdl/rchp_pkg.sv =====
`timescale 1ns / 1ps
package rchp_pkg;

  // pool geometry
  localparam int PoolBytes  = 65536;
  localparam int MaxEntries = 64;
  localparam int HandleBits = 16;

  // operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_ADDREF = 2'd2;
  localparam logic [1:0] OP_DROP   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADHDL  = 2'd2;

  localparam int RefsBits = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] handle_in;
    logic [16:0] request_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle_out;
    logic [15:0] offset;
    logic        compacted;
    logic [6:0]  live_objects;
    logic [16:0] bytes_in_use;
    logic [16:0] bytes_collected;
  } rsp_t;

endpackage

// ===== hdl/rchp_stream_if.sv =====
`timescale 1ns / 1ps
interface rchp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/refcounted_compacting_handle_pool_core.sv =====
`timescale 1ns / 1ps
// Handle pool with reference counts and compaction. One item at a time:
// an allocate without compaction goes from the check state through the
// allocate state to the output state; retrieve, add and drop walk the
// table one entry a cycle through the memory read port and stop at the
// first match or at the end of the table; an allocate that compacts first
// walks the whole table. Result is held in an output register; the next
// item is taken while it waits to be collected, and a finished item waits
// until that register is free.
module refcounted_compacting_handle_pool_core (
  input  logic         clk,
  input  logic         rst,
  rchp_stream_if.sink   in_ch,
  rchp_stream_if.source out_ch
);
  localparam int POOL_BYTES  = rchp_pkg::PoolBytes;
  localparam int MAX_ENTRIES = rchp_pkg::MaxEntries;
  localparam int HANDLE_BITS = rchp_pkg::HandleBits;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int BW = $clog2(POOL_BYTES + 1);
  localparam int EW = HANDLE_BITS + BW + rchp_pkg::RefsBits + BW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_CHK = 6'b000100,
    S_CMP  = 6'b001000, S_ALLOC = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state;
  rchp_pkg::req_t req;
  logic [CW-1:0] entry_count, rptr, wptr;
  logic [HANDLE_BITS-1:0] next_handle;
  logic [BW-1:0] taken_bytes, gone, pos;
  logic rd_valid;
  logic [AW-1:0] rd_idx;
  rchp_pkg::rsp_t res;
  rchp_pkg::rsp_t out_res;
  logic res_valid;

  // entry record: handle, offset, refs, size
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [HANDLE_BITS-1:0] r_hdl;
  logic [BW-1:0] r_off, r_size;
  logic [rchp_pkg::RefsBits-1:0] r_refs;
  assign {r_hdl, r_off, r_refs, r_size} = rdata;

  rchp_table_mem #(.Depth(MAX_ENTRIES), .Width(EW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [BW:0] freeb;
  logic [BW:0] reqx;
  logic hit;
  assign freeb = (BW+1)'(POOL_BYTES) - {1'b0, taken_bytes};
  assign reqx  = (BW+1)'(req.request_bytes);
  assign hit   = rd_valid && (r_hdl == HANDLE_BITS'(req.handle_in));
  assign raddr = rptr[AW-1:0];

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = res_valid;
  assign out_ch.data  = out_res;

  // memory write port
  always_comb begin
    we = 1'b0;
    waddr = rd_idx;
    wdata = rdata;
    case (state)
      S_SCAN: begin
        if (hit && req.kind == rchp_pkg::OP_ADDREF && r_refs != '1) begin
          we = 1'b1;
          wdata = {r_hdl, r_off, r_refs + 1'b1, r_size};
        end else if (hit && req.kind == rchp_pkg::OP_DROP && r_refs != '0) begin
          we = 1'b1;
          wdata = {r_hdl, r_off, r_refs - 1'b1, r_size};
        end
      end
      S_CMP: begin
        we = rd_valid && r_refs != '0;
        waddr = wptr[AW-1:0];
        wdata = {r_hdl, pos, r_refs, r_size};
      end
      S_ALLOC: begin
        we = (freeb > reqx) && (entry_count < CW'(MAX_ENTRIES)) && (next_handle != '0);
        waddr = entry_count[AW-1:0];
        wdata = {next_handle, taken_bytes, rchp_pkg::RefsBits'(1), BW'(req.request_bytes)};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      next_handle <= HANDLE_BITS'(1);
      taken_bytes <= '0;
      res_valid <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (res_valid && out_ch.ready && state != S_OUT) res_valid <= 1'b0;
      rd_idx <= rptr[AW-1:0];
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          req <= in_ch.data;
          res <= '0;
          rptr <= '0;
          wptr <= '0;
          gone <= '0;
          pos <= '0;
          if (in_ch.data.kind == rchp_pkg::OP_ALLOC) state <= S_CHK;
          else state <= S_SCAN;
        end
        S_SCAN: begin
          // walk entries, one read a cycle; stop on first match
          if (hit) begin
            if (r_refs == '0 && req.kind != rchp_pkg::OP_ADDREF)
              res.status <= rchp_pkg::ST_BADHDL;
            else if (req.kind == rchp_pkg::OP_GET)
              res.offset <= 16'(r_off);
            rd_valid <= 1'b0;
            state <= S_OUT;
          end else if (rptr >= entry_count && !rd_valid && rptr != '0) begin
            if (req.kind != rchp_pkg::OP_ADDREF) res.status <= rchp_pkg::ST_BADHDL;
            state <= S_OUT;
          end else if (entry_count == '0) begin
            if (req.kind != rchp_pkg::OP_ADDREF) res.status <= rchp_pkg::ST_BADHDL;
            state <= S_OUT;
          end else if (rptr < entry_count) begin
            rd_valid <= 1'b1;
            rptr <= rptr + 1'b1;
          end else begin
            rd_valid <= 1'b0;
          end
        end
        S_CHK: begin
          if (freeb < reqx) begin
            state <= S_CMP;
          end else state <= S_ALLOC;
        end
        S_CMP: begin
          // repack live entries from offset 0
          if (rd_valid) begin
            if (r_refs == '0) gone <= gone + r_size;
            else begin
              pos <= pos + r_size;
              wptr <= wptr + 1'b1;
            end
          end
          if (rptr < entry_count) begin
            rd_valid <= 1'b1;
            rptr <= rptr + 1'b1;
          end else begin
            rd_valid <= 1'b0;
            if (!rd_valid) begin
              entry_count <= wptr;
              taken_bytes <= pos;
              res.compacted <= 1'b1;
              res.live_objects <= 7'(wptr);
              res.bytes_in_use <= 17'(pos);
              res.bytes_collected <= 17'(gone);
              state <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          if (we) begin
            res.handle_out <= 16'(next_handle);
            res.offset <= 16'(taken_bytes);
            taken_bytes <= taken_bytes + BW'(req.request_bytes);
            entry_count <= entry_count + 1'b1;
            next_handle <= next_handle + 1'b1;
          end else res.status <= rchp_pkg::ST_NOSPACE;
          state <= S_OUT;
        end
        S_OUT: begin
          // hand over once the output register is free
          if (!res_valid || out_ch.ready) begin
            out_res <= res;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/rchp_table_mem.sv =====
`timescale 1ns / 1ps
// Entry table: one write port, one registered read port.
module rchp_table_mem #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/rchp_checker.sv =====
`timescale 1ns / 1ps
module rchp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rchp_pkg::rsp_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_fail_nohandle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != rchp_pkg::ST_OK |-> out_data.handle_out == '0)
    else $error("handle on failure");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.compacted |-> out_data.bytes_collected == '0)
    else $error("stats without compaction");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accept while busy");
endmodule

bind refcounted_compacting_handle_pool_core rchp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== test/refcounted_compacting_handle_pool_core_tb.sv =====
`timescale 1ns / 1ps
module refcounted_compacting_handle_pool_core_tb;

  localparam int PoolBytes  = rchp_pkg::PoolBytes;
  localparam int MaxEntries = rchp_pkg::MaxEntries;
  localparam int RefsMax    = 65535;
  localparam int StallLimit = 20000;
  localparam int RandItems  = 400;

  logic clk;
  logic rst;

  rchp_stream_if #(.payload_t(rchp_pkg::req_t)) in_ch ();
  rchp_stream_if #(.payload_t(rchp_pkg::rsp_t)) out_ch ();

  refcounted_compacting_handle_pool_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  // shadow of the handle table
  logic [15:0] tbl_handle [MaxEntries];
  logic [15:0] tbl_offset [MaxEntries];
  logic [16:0] tbl_size   [MaxEntries];
  logic [15:0] tbl_refs   [MaxEntries];
  int          tbl_count;
  logic [15:0] next_hdl;
  int          used_bytes;

  rchp_pkg::rsp_t pending_rsp [$];
  int   fail_count;
  bit   quiet;      // no idling in the final stretch
  bit   hold_off;   // long receiver stall

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_slot(logic [15:0] h);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_handle[i] == h) return i;
    return -1;
  endfunction

  // compute the result of one operation and update the shadow table
  function automatic rchp_pkg::rsp_t pool_apply(rchp_pkg::req_t rq);
    rchp_pkg::rsp_t r;
    int idx;
    int w;
    int pos;
    int gone;
    r = '0;
    case (rq.kind)
      rchp_pkg::OP_ALLOC: begin
        if (PoolBytes - used_bytes < int'(rq.request_bytes)) begin
          w = 0; pos = 0; gone = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_refs[i] == 0) begin
              gone += tbl_size[i];
            end else begin
              tbl_handle[w] = tbl_handle[i];
              tbl_size[w]   = tbl_size[i];
              tbl_refs[w]   = tbl_refs[i];
              tbl_offset[w] = pos[15:0];
              pos += tbl_size[i];
              w++;
            end
          end
          tbl_count = w;
          used_bytes = pos;
          r.compacted = 1'b1;
          r.live_objects = w[6:0];
          r.bytes_in_use = pos[16:0];
          r.bytes_collected = gone[16:0];
        end
        if (PoolBytes - used_bytes > int'(rq.request_bytes) && tbl_count < MaxEntries &&
            next_hdl != 0) begin
          tbl_handle[tbl_count] = next_hdl;
          tbl_offset[tbl_count] = used_bytes[15:0];
          tbl_size[tbl_count]   = rq.request_bytes;
          tbl_refs[tbl_count]   = 16'd1;
          tbl_count++;
          r.handle_out = next_hdl;
          r.offset = used_bytes[15:0];
          used_bytes += rq.request_bytes;
          next_hdl = next_hdl + 16'd1;
        end else begin
          r.status = rchp_pkg::ST_NOSPACE;
        end
      end
      rchp_pkg::OP_ADDREF: begin
        idx = find_slot(rq.handle_in);
        if (idx >= 0 && tbl_refs[idx] < RefsMax) tbl_refs[idx]++;
      end
      default: begin
        idx = find_slot(rq.handle_in);
        if (idx < 0 || tbl_refs[idx] == 0) r.status = rchp_pkg::ST_BADHDL;
        else if (rq.kind == rchp_pkg::OP_GET) r.offset = tbl_offset[idx];
        else tbl_refs[idx]--;
      end
    endcase
    return r;
  endfunction

  // directed table; known results typed in where obvious
  typedef struct {
    rchp_pkg::req_t rq;
    bit   known;
    rchp_pkg::rsp_t rs;
  } row_t;
  row_t dir_rows [$];

  function automatic rchp_pkg::rsp_t mk_rsp(logic [1:0] st, logic [15:0] h,
                                            logic [15:0] off);
    rchp_pkg::rsp_t r;
    r = '0;
    r.status = st; r.handle_out = h; r.offset = off;
    return r;
  endfunction

  task automatic add_row(logic [1:0] k, logic [15:0] h, logic [16:0] b,
                         bit kn = 1'b0, rchp_pkg::rsp_t rs = '0);
    row_t r;
    r.rq.kind = k; r.rq.handle_in = h; r.rq.request_bytes = b;
    r.known = kn; r.rs = rs;
    dir_rows.push_back(r);
  endtask

  // send one transfer, predicting on acceptance; valid stays high between
  // back-to-back transfers
  task automatic send_op(rchp_pkg::req_t rq, bit kn, rchp_pkg::rsp_t rs);
    rchp_pkg::rsp_t pr;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= rq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pr = pool_apply(rq);
    if (kn) begin
      if (pr.status != rs.status) begin
        $error("status exp %0d pred %0d", rs.status, pr.status); fail_count++; end
      if (pr.handle_out != rs.handle_out) begin
        $error("handle_out exp %0d pred %0d", rs.handle_out, pr.handle_out);
        fail_count++;
      end
      if (pr.offset != rs.offset) begin
        $error("offset exp %0d pred %0d", rs.offset, pr.offset); fail_count++; end
      if (pr.compacted != rs.compacted) begin
        $error("compacted exp %0d pred %0d", rs.compacted, pr.compacted); fail_count++; end
    end
    pending_rsp.push_back(pr);
  endtask

  function automatic logic [15:0] pick_handle();
    int s;
    s = $urandom_range(0, 9);
    if (s < 7 && tbl_count > 0) return tbl_handle[$urandom_range(0, tbl_count - 1)];
    if (s < 9) return next_hdl - 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic logic [16:0] pick_bytes();
    int s;
    s = $urandom_range(0, 19);
    if (s < 14) return 17'($urandom_range(0, 4000));
    if (s < 17) return 17'($urandom_range(0, 20000));
    if (s < 19) return 17'($urandom_range(0, 65536));
    return $urandom_range(0, 1) ? 17'd65536 : 17'h0FFFF;
  endfunction

  // receiver side
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    rchp_pkg::rsp_t e, a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (pending_rsp.size() == 0) begin
        $error("result with nothing expected: %h", a);
        fail_count++;
      end else begin
        e = pending_rsp.pop_front();
        if (a.status !== e.status) begin
          $error("status exp %0d act %0d", e.status, a.status); fail_count++; end
        if (a.handle_out !== e.handle_out) begin
          $error("handle_out exp %0d act %0d", e.handle_out, a.handle_out); fail_count++; end
        if (a.offset !== e.offset) begin
          $error("offset exp %0d act %0d", e.offset, a.offset); fail_count++; end
        if (a.compacted !== e.compacted) begin
          $error("compacted exp %0d act %0d", e.compacted, a.compacted); fail_count++; end
        if (a.live_objects !== e.live_objects) begin
          $error("live_objects exp %0d act %0d", e.live_objects, a.live_objects);
          fail_count++;
        end
        if (a.bytes_in_use !== e.bytes_in_use) begin
          $error("bytes_in_use exp %0d act %0d", e.bytes_in_use, a.bytes_in_use);
          fail_count++;
        end
        if (a.bytes_collected !== e.bytes_collected) begin
          $error("bytes_collected exp %0d act %0d", e.bytes_collected, a.bytes_collected);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rchp_pkg::req_t rq;
    int k;
    fail_count = 0; quiet = 0; hold_off = 0;
    tbl_count = 0; next_hdl = 16'd1; used_bytes = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    add_row(rchp_pkg::OP_GET,    16'd0,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_BADHDL, 16'd0, 16'd0));
    add_row(rchp_pkg::OP_DROP,   16'hFFFF, 17'h1FFFF, 1'b1,
            mk_rsp(rchp_pkg::ST_BADHDL, 16'd0, 16'd0));
    add_row(rchp_pkg::OP_ADDREF, 16'd5,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_OK, 16'd0, 16'd0));
    add_row(rchp_pkg::OP_ALLOC,  16'd0,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_OK, 16'd1, 16'd0));
    add_row(rchp_pkg::OP_ALLOC,  16'hFFFF, 17'd100,   1'b1,
            mk_rsp(rchp_pkg::ST_OK, 16'd2, 16'd0));
    add_row(rchp_pkg::OP_ALLOC,  16'd0,    17'd65536);
    add_row(rchp_pkg::OP_ALLOC,  16'd0,    17'h1FFFF);
    add_row(rchp_pkg::OP_GET,    16'd2,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_OK, 16'd0, 16'd0));
    add_row(rchp_pkg::OP_ALLOC,  16'd0,    17'd30000, 1'b1,
            mk_rsp(rchp_pkg::ST_OK, 16'd3, 16'd100));
    add_row(rchp_pkg::OP_GET,    16'd3,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_OK, 16'd0, 16'd100));
    add_row(rchp_pkg::OP_ADDREF, 16'd3,    17'd0);
    add_row(rchp_pkg::OP_DROP,   16'd3,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_OK, 16'd0, 16'd0));
    add_row(rchp_pkg::OP_DROP,   16'd3,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_OK, 16'd0, 16'd0));
    add_row(rchp_pkg::OP_DROP,   16'd3,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_BADHDL, 16'd0, 16'd0));
    add_row(rchp_pkg::OP_GET,    16'd3,    17'd0,     1'b1,
            mk_rsp(rchp_pkg::ST_BADHDL, 16'd0, 16'd0));
    add_row(rchp_pkg::OP_ADDREF, 16'd3,    17'd0);
    add_row(rchp_pkg::OP_DROP,   16'd3,    17'd0);
    add_row(rchp_pkg::OP_DROP,   16'd2,    17'd0);
    add_row(rchp_pkg::OP_ALLOC,  16'd0,    17'd40000);
    add_row(rchp_pkg::OP_ALLOC,  16'd0,    17'd35436);
    add_row(rchp_pkg::OP_GET,    16'd4,    17'd0);
    add_row(rchp_pkg::OP_DROP,   16'd1,    17'd0);
    add_row(rchp_pkg::OP_ALLOC,  16'd0,    17'd25000);
    foreach (dir_rows[i]) send_op(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].rs);

    // table fill: many tiny allocations then one that must compact
    for (int i = 0; i < 70; i++) begin
      rq.kind = rchp_pkg::OP_ALLOC; rq.handle_in = 16'($urandom);
      rq.request_bytes = 17'($urandom_range(0, 3));
      send_op(rq, 1'b0, '0);
    end
    rq.kind = rchp_pkg::OP_ALLOC; rq.request_bytes = 17'd65000;
    send_op(rq, 1'b0, '0);

    // random part; a long receiver stall partway through
    for (int n = 0; n < RandItems; n++) begin
      if (n == 150) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      if (n == RandItems - 80) quiet = 1;
      k = $urandom_range(0, 9);
      rq.handle_in = pick_handle();
      rq.request_bytes = pick_bytes();
      if (k < 3) rq.kind = rchp_pkg::OP_ALLOC;
      else if (k < 5) rq.kind = rchp_pkg::OP_GET;
      else if (k < 7) rq.kind = rchp_pkg::OP_ADDREF;
      else rq.kind = rchp_pkg::OP_DROP;
      if ($urandom_range(0, 1))
        rq.handle_in = rq.handle_in ^ 16'($urandom_range(0, 1) << $urandom_range(0, 15));
      send_op(rq, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
